// File: hw/rtl/rbsor_pkg.sv
`timescale 1ns / 1ps

package rbsor_pkg;

  localparam int GRID_SIDE = 66;
  localparam int NCELLS    = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W    = $clog2(NCELLS);
  // Row and column counters must hold GRID_SIDE itself.
  localparam int POS_W     = $clog2(GRID_SIDE + 1);
  localparam int TERM_W    = 32 + 2 * POS_W + 2;
  localparam int MAG_W     = TERM_W;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_SOLVE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] REG_RELAX = 2'd0;
  localparam logic [1:0] REG_TOL   = 2'd1;
  localparam logic [1:0] REG_MAXIT = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [31:0] cell_in;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] cell_out;
    logic [9:0]         iterations_used;
    logic [30:0]        final_change;
    logic signed [63:0] weighted_sum;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ITER,
    S_ROW,
    S_CELL,
    S_SWEEP_END,
    S_ITER_END,
    S_WSUM,
    S_WDIV,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/rbsor_ram.sv
`timescale 1ns / 1ps

module rbsor_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rbsor_cdiv.sv
`timescale 1ns / 1ps

// Division of a magnitude by the grid area: the magnitude is multiplied by a
// rounded-up reciprocal in four partial products, one per cycle, which gives
// the exact floor for every magnitude that fits in MAG_W bits.
module rbsor_cdiv (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [rbsor_pkg::MAG_W-1:0] dividend,
  output logic                      done,
  output logic [rbsor_pkg::MAG_W-1:0] quotient
);
  import rbsor_pkg::*;

  localparam int HALF  = MAG_W / 2;
  localparam int RCP_W = MAG_W + 1;
  localparam int SH    = MAG_W + $clog2(NCELLS);
  localparam int ACC_W = MAG_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SH) + 64'(NCELLS - 1)) / 64'(NCELLS));

  logic [MAG_W-1:0]      x;
  logic [ACC_W-1:0]      acc;
  logic [1:0]            step;
  logic                  running;
  logic [HALF-1:0]       op_a;
  logic [RCP_W-HALF-1:0] op_b;
  logic [RCP_W-1:0]      pp;
  logic [ACC_W-1:0]      pp_sh;

  always_comb begin
    op_a = step[1] ? x[MAG_W-1:HALF] : x[HALF-1:0];
    op_b = step[0] ? RECIP[RCP_W-1:HALF] : (RCP_W-HALF)'(RECIP[HALF-1:0]);
    pp   = {{(RCP_W - HALF){1'b0}}, op_a} * {{HALF{1'b0}}, op_b};
    case (step)
      2'd0:    pp_sh = ACC_W'(pp);
      2'd3:    pp_sh = ACC_W'(pp) << (2 * HALF);
      default: pp_sh = ACC_W'(pp) << HALF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        x       <= dividend;
        acc     <= '0;
        step    <= '0;
        running <= 1'b1;
      end else if (running) begin
        acc  <= acc + pp_sh;
        step <= step + 2'd1;
        if (step == 2'd3) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = MAG_W'(acc[ACC_W-1:SH]);

endmodule

// File: hw/rtl/red_black_sor_grid_solver_top.sv
`timescale 1ns / 1ps

// Channel   Signals                                  Transfer
// input     start, busy, item                        start && !busy
// result    result_valid, result                     one-cycle strobe, no stall
// config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// A read answers in the cycle after it is accepted, and loads and reads stream
// one per cycle. A solve holds busy high while it relaxes every interior cell
// once per iteration (five reads of the single grid port, then the relaxation
// arithmetic), with a row step per row and colour, and then while it forms the
// weighted sum over every cell (a fetch and scale, then the reciprocal divide).
// The summary shows in the first cycle with busy low. Reset is synchronous and
// needs no clearing pass; results cannot be held off by the receiver.
module red_black_sor_grid_solver_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rbsor_pkg::in_t      item,
  output logic                result_valid,
  output rbsor_pkg::out_t     result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import rbsor_pkg::*;

  localparam logic [POS_W-1:0] LAST_IN  = POS_W'(GRID_SIDE - 2);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(GRID_SIDE - 1);

  state_t state, state_next;

  logic [14:0] relax_factor;
  logic [30:0] tolerance;
  logic [9:0]  max_iterations;

  logic              parity;
  logic [POS_W-1:0]  r, c, c_first;
  logic [ADDR_W-1:0] base, k;
  logic [3:0]        phase;
  logic signed [34:0] acc;
  logic signed [31:0] cellv;
  logic signed [33:0] d;
  logic signed [49:0] prod;
  logic signed [35:0] b_r;
  logic signed [36:0] upd_sum;
  logic [35:0]        b_abs;
  logic [30:0]        b_mag;
  logic [31:0]        upd_val;
  logic [30:0]        worst, last;
  logic [9:0]         used;
  logic signed [32+POS_W:0]  t1;
  logic signed [TERM_W-1:0]  t2;
  logic               neg;
  logic signed [63:0] wsum;
  logic signed [MAG_W:0] q_signed;
  logic signed [64:0]    wsum_add;
  logic signed [63:0]    wsum_sat;

  logic              accept, in_grid;
  logic [ADDR_W-1:0] item_addr;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [31:0]       wdata, rdata;
  logic              div_go, div_done;
  logic [MAG_W-1:0]  div_in, div_q;
  logic              to_wsum;

  logic        rd_pend, rd_inside;
  logic        sum_valid;
  out_t        sum_out, read_out;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_grid   = (item.row < GRID_SIDE) && (item.col < GRID_SIDE);
  assign item_addr = ADDR_W'(item.row * GRID_SIDE + item.col);
  assign k         = base + ADDR_W'(c);
  // First column of this colour in row r.
  assign c_first   = (r[0] != parity) ? POS_W'(1) : POS_W'(2);

  always_comb begin
    upd_sum = 37'(cellv) + 37'(b_r);
    if (upd_sum[36:31] != {6{upd_sum[36]}}) begin
      upd_val = upd_sum[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      upd_val = upd_sum[31:0];
    end
    b_abs = b_r[35] ? 36'(-b_r) : 36'(b_r);
    b_mag = (b_abs > 36'h07FFF_FFFF) ? 31'h7FFF_FFFF : b_abs[30:0];
    q_signed = neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    wsum_add = 65'(wsum) + 65'(q_signed);
    if (wsum_add[64] != wsum_add[63]) begin
      wsum_sat = wsum_add[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      wsum_sat = wsum_add[63:0];
    end
    div_in = t2[TERM_W-1] ? MAG_W'(-t2) : MAG_W'(t2);
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = k;
    wdata      = upd_val;
    raddr      = k;
    div_go     = 1'b0;
    to_wsum    = 1'b0;
    case (state)
      S_IDLE: begin
        raddr = item_addr;
        if (accept) begin
          case (item.action)
            ACT_LOAD: begin
              we    = in_grid;
              waddr = item_addr;
              wdata = item.cell_in;
            end
            ACT_SOLVE: state_next = S_ITER;
            default: ;
          endcase
        end
      end
      S_ITER: begin
        if (used == max_iterations) begin
          to_wsum    = 1'b1;
          state_next = S_WSUM;
        end else begin
          state_next = S_ROW;
        end
      end
      S_ROW: begin
        if (r > LAST_IN) begin
          state_next = S_SWEEP_END;
        end else if (c_first <= LAST_IN) begin
          state_next = S_CELL;
        end
      end
      S_CELL: begin
        case (phase)
          4'd0: raddr = k - ADDR_W'(GRID_SIDE);
          4'd1: raddr = k + ADDR_W'(GRID_SIDE);
          4'd2: raddr = k - ADDR_W'(1);
          4'd3: raddr = k + ADDR_W'(1);
          4'd8: begin
            we = 1'b1;
            if (c + POS_W'(2) > LAST_IN) begin
              state_next = S_ROW;
            end
          end
          default: ;
        endcase
      end
      S_SWEEP_END: state_next = parity ? S_ROW : S_ITER_END;
      S_ITER_END: begin
        if (last < tolerance) begin
          to_wsum    = 1'b1;
          state_next = S_WSUM;
        end else begin
          state_next = S_ITER;
        end
      end
      S_WSUM: begin
        if (phase == 4'd3) begin
          div_go     = 1'b1;
          state_next = S_WDIV;
        end
      end
      S_WDIV: begin
        if (div_done) begin
          state_next = (c == LAST_POS && r == LAST_POS) ? S_DONE : S_WSUM;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relax_factor   <= 15'd8192;
      tolerance      <= '0;
      max_iterations <= 10'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RELAX: relax_factor   <= cfg_data[14:0];
        REG_TOL:   tolerance      <= cfg_data[30:0];
        REG_MAXIT: max_iterations <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      sum_valid <= 1'b0;
      last      <= '0;
      used      <= '0;
      phase     <= '0;
    end else begin
      rd_pend   <= 1'b0;
      sum_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && item.action == ACT_READ) begin
            rd_pend   <= 1'b1;
            rd_inside <= in_grid;
          end
          if (accept && item.action == ACT_SOLVE) begin
            used <= '0;
            last <= '0;
          end
        end
        S_ITER: begin
          if (used != max_iterations) begin
            used   <= used + 10'd1;
            parity <= 1'b1;
            worst  <= '0;
            r      <= POS_W'(1);
            base   <= ADDR_W'(GRID_SIDE);
          end
        end
        S_ROW: begin
          if (r <= LAST_IN) begin
            if (c_first <= LAST_IN) begin
              c     <= c_first;
              phase <= '0;
            end else begin
              r    <= r + POS_W'(1);
              base <= base + ADDR_W'(GRID_SIDE);
            end
          end
        end
        S_CELL: begin
          phase <= phase + 4'd1;
          case (phase)
            4'd1: acc <= 35'($signed(rdata));
            4'd2, 4'd3, 4'd4: acc <= acc + 35'($signed(rdata));
            4'd5: begin
              cellv <= $signed(rdata);
              d     <= 34'(acc >>> 2) - 34'($signed(rdata));
            end
            4'd6: prod <= $signed({1'b0, relax_factor}) * d;
            4'd7: b_r <= 36'((prod + 50'sd8192) >>> 14);
            4'd8: begin
              if (parity && b_mag > worst) begin
                worst <= b_mag;
              end
              phase <= '0;
              if (c + POS_W'(2) > LAST_IN) begin
                r    <= r + POS_W'(1);
                base <= base + ADDR_W'(GRID_SIDE);
              end else begin
                c <= c + POS_W'(2);
              end
            end
            default: ;
          endcase
        end
        S_SWEEP_END: begin
          if (parity) begin
            last   <= worst;
            parity <= 1'b0;
            r      <= POS_W'(1);
            base   <= ADDR_W'(GRID_SIDE);
          end
        end
        S_WSUM: begin
          phase <= phase + 4'd1;
          case (phase)
            4'd1: t1 <= $signed(rdata) * $signed({1'b0, r + POS_W'(1)});
            4'd2: t2 <= t1 * $signed({1'b0, c + POS_W'(1)});
            4'd3: neg <= t2[TERM_W-1];
            default: ;
          endcase
        end
        S_WDIV: begin
          if (div_done) begin
            wsum  <= wsum_sat;
            phase <= '0;
            if (c == LAST_POS) begin
              c    <= '0;
              r    <= r + POS_W'(1);
              base <= base + ADDR_W'(GRID_SIDE);
            end else begin
              c <= c + POS_W'(1);
            end
          end
        end
        S_DONE: begin
          sum_valid                <= 1'b1;
          sum_out.result_kind      <= 1'b1;
          sum_out.cell_out         <= '0;
          sum_out.iterations_used  <= used;
          sum_out.final_change     <= last;
          sum_out.weighted_sum     <= wsum;
        end
        default: ;
      endcase
      if (to_wsum) begin
        r     <= '0;
        c     <= '0;
        base  <= '0;
        phase <= '0;
        wsum  <= '0;
      end
    end
  end

  always_comb begin
    read_out                 = '0;
    read_out.cell_out        = rd_inside ? $signed(rdata) : 32'sd0;
  end

  assign result_valid = rd_pend || sum_valid;
  assign result       = sum_valid ? sum_out : read_out;

  rbsor_ram #(
    .WIDTH(32),
    .DEPTH(NCELLS)
  ) u_grid (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rbsor_cdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_in),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

// File: hw/rtl/rbsor_checker.sv
`timescale 1ns / 1ps

module rbsor_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input rbsor_pkg::in_t  item,
  input logic            result_valid,
  input rbsor_pkg::out_t result
);
  import rbsor_pkg::*;

  // A cell read answers in the cycle after its transaction.
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.result_kind |->
      $past(start && !busy && item.action == ACT_READ))
    else $error("cell read result without a read one cycle earlier");

  a_solve_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.action == ACT_SOLVE |=> busy)
    else $error("solve accepted but block not busy");

  // The end of a solve is always marked by its summary.
  a_summary_at_end: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> result_valid && result.result_kind)
    else $error("solve ended without a summary");

  a_summary_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind |-> result.cell_out == 32'sd0)
    else $error("summary carries cell data");

endmodule

bind red_black_sor_grid_solver_top rbsor_checker u_chk (.*);
